[rtl/pisc_pkg.sv]
package pisc_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int IDX_W      = 32;
  localparam int PAGE_W     = 32;
  localparam int OFF_W      = 16;
  localparam int PSIZE_W    = 17;
  localparam int LFSR_W     = 16;
  localparam int CNT_W      = 32;
  localparam int SLOTF_W    = 2;
  localparam int STEP_W     = $clog2(IDX_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_VICTIM_SEED = CFG_IDX_W'(1);

  localparam logic [PSIZE_W-1:0] PAGE_SIZE_RESET = PSIZE_W'(256);
  localparam logic [PSIZE_W-1:0] PAGE_SIZE_MAX   = PSIZE_W'(65536);
  localparam logic [LFSR_W-1:0]  SEED_RESET      = LFSR_W'(44257);
  localparam logic [LFSR_W-1:0]  LFSR_POLY       = LFSR_W'(16'hB400);

  typedef enum logic {
    KIND_ACCESS = 1'b0,
    KIND_FLUSH  = 1'b1
  } kind_e;

  typedef struct packed {
    logic               hit;
    logic [SLOTF_W-1:0] slot;
    logic [OFF_W-1:0]   offset;
    logic [PAGE_W-1:0]  page_number;
    logic               writeback_valid;
    logic [PAGE_W-1:0]  writeback_page;
    logic [CNT_W-1:0]   hit_total;
    logic [CNT_W-1:0]   fault_total;
    logic               last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic              start;
    logic              step;
    logic              resolve;
    logic              flush_emit;
    logic              flush_empty;
    logic [SLOT_W-1:0] ptr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic any_valid;
    logic cur_valid;
    logic above_valid;
  } sts_t;

  function automatic logic [LFSR_W-1:0] lfsr_step(logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] n;
    n = v >> 1;
    if (v[0]) begin
      n = n ^ LFSR_POLY;
    end
    return n;
  endfunction

  function automatic logic [SLOTF_W-1:0] slot_field(logic [SLOT_W-1:0] s);
    logic [SLOT_W+SLOTF_W-1:0] w;
    w = (SLOT_W + SLOTF_W)'(s);
    return w[SLOTF_W-1:0];
  endfunction

endpackage

[rtl/pisc_in_if.sv]
interface pisc_in_if
  import pisc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [IDX_W-1:0] word_index;

  modport source (output valid, kind, word_index, input ready);
  modport sink   (input valid, kind, word_index, output ready);
endinterface

[rtl/pisc_out_if.sv]
interface pisc_out_if
  import pisc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [SLOTF_W-1:0] slot;
  logic [OFF_W-1:0]   offset;
  logic [PAGE_W-1:0]  page_number;
  logic               writeback_valid;
  logic [PAGE_W-1:0]  writeback_page;
  logic [CNT_W-1:0]   hit_total;
  logic [CNT_W-1:0]   fault_total;
  logic               last;

  modport source (output valid, hit, slot, offset, page_number, writeback_valid,
                  writeback_page, hit_total, fault_total, last, input ready);
  modport sink   (input valid, hit, slot, offset, page_number, writeback_valid,
                  writeback_page, hit_total, fault_total, last, output ready);
endinterface

[rtl/pisc_cfg_if.sv]
interface pisc_cfg_if
  import pisc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/pisc_ctrl.sv]
module pisc_ctrl
  import pisc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_kind_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_RESOLVE,
    ST_FLUSH,
    ST_EMPTY
  } state_e;

  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(IDX_W - 1);

  state_e            state_q;
  logic [STEP_W-1:0] cnt_q;
  logic [SLOT_W-1:0] ptr_q;
  logic              take;

  assign in_ready_o = (state_q == ST_IDLE);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o             = '0;
    cmd_o.ptr         = ptr_q;
    cmd_o.start       = take && (in_kind_i == KIND_ACCESS);
    cmd_o.step        = (state_q == ST_DIVIDE);
    cmd_o.resolve     = (state_q == ST_RESOLVE) && sts_i.out_free;
    cmd_o.flush_emit  = (state_q == ST_FLUSH) && sts_i.cur_valid && sts_i.out_free;
    cmd_o.flush_empty = (state_q == ST_EMPTY) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ptr_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          ptr_q <= '0;
          if (take) begin
            if (in_kind_i == KIND_FLUSH) begin
              state_q <= sts_i.any_valid ? ST_FLUSH : ST_EMPTY;
            end else begin
              state_q <= ST_DIVIDE;
            end
          end
        end
        ST_DIVIDE: begin
          cnt_q <= cnt_q + STEP_W'(1);
          if (cnt_q == LAST_STEP) begin
            state_q <= ST_RESOLVE;
          end
        end
        ST_RESOLVE: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        ST_FLUSH: begin
          // while the pointer slot is empty, a loaded slot above it always exists
          if (!sts_i.cur_valid) begin
            ptr_q <= ptr_q + SLOT_W'(1);
          end else if (sts_i.out_free) begin
            if (sts_i.above_valid) begin
              ptr_q <= ptr_q + SLOT_W'(1);
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_EMPTY: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/pisc_dp.sv]
module pisc_dp
  import pisc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] word_index_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  pisc_cfg_if.sink         cfg_i,
  pisc_out_if.source       out_o
);

  // configuration and replacement state
  logic [PSIZE_W-1:0] psize_cfg_q;
  logic [LFSR_W-1:0]  lfsr_q;
  logic [CNT_W-1:0]   hit_cnt_q;
  logic [CNT_W-1:0]   fault_cnt_q;

  // slots
  logic [SLOT_COUNT-1:0] slot_valid_q;
  logic [PAGE_W-1:0]     slot_page_q [SLOT_COUNT];

  // serial divider and victim slot
  logic [PSIZE_W-1:0] ps_q;
  logic [IDX_W-1:0]   quo_q;
  logic [OFF_W-1:0]   rem_q;
  logic [SLOT_W-1:0]  vrem_q;

  // output register
  out_t out_q;
  logic out_valid_q;

  logic [PSIZE_W-1:0] ps_use;
  logic [OFF_W:0]     trial;
  logic               trial_ge;
  logic [OFF_W:0]     trial_sub;
  logic [LFSR_W-1:0]  lfsr_next;
  logic               hit_any;
  logic [SLOT_W-1:0]  hit_idx;
  logic               above;
  logic [SLOT_W-1:0]  rd_sel;
  logic [PAGE_W-1:0]  rd_page;
  logic               rd_valid;
  logic [CNT_W-1:0]   hit_cnt_inc;
  logic [CNT_W-1:0]   fault_cnt_inc;
  logic               out_load;
  logic               cfg_take;

  assign cfg_i.ready = 1'b1;
  assign cfg_take    = cfg_i.valid && cfg_i.ready;

  always_comb begin
    if (psize_cfg_q == '0) begin
      ps_use = PSIZE_W'(1);
    end else if (psize_cfg_q > PAGE_SIZE_MAX) begin
      ps_use = PAGE_SIZE_MAX;
    end else begin
      ps_use = psize_cfg_q;
    end
  end

  // restoring division, one quotient bit a step
  assign trial     = {rem_q, quo_q[IDX_W-1]};
  assign trial_ge  = (PSIZE_W'(trial) >= ps_q);
  assign trial_sub = trial - (OFF_W + 1)'(ps_q);

  // victim is the advanced lfsr value modulo the slot count
  assign lfsr_next = lfsr_step(lfsr_q);

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    above   = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!hit_any && slot_valid_q[i] && (slot_page_q[i] == quo_q)) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (slot_valid_q[i] && (SLOT_W'(i) > cmd_i.ptr)) begin
        above = 1'b1;
      end
    end
  end

  assign rd_sel   = cmd_i.flush_emit ? cmd_i.ptr : vrem_q;
  assign rd_page  = slot_page_q[rd_sel];
  assign rd_valid = slot_valid_q[rd_sel];

  assign hit_cnt_inc   = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + CNT_W'(1);
  assign fault_cnt_inc = (fault_cnt_q == '1) ? fault_cnt_q : fault_cnt_q + CNT_W'(1);

  assign out_load = cmd_i.resolve || cmd_i.flush_emit || cmd_i.flush_empty;

  assign sts_o.out_free    = !out_valid_q || out_o.ready;
  assign sts_o.any_valid   = |slot_valid_q;
  assign sts_o.cur_valid   = slot_valid_q[cmd_i.ptr];
  assign sts_o.above_valid = above;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psize_cfg_q  <= PAGE_SIZE_RESET;
      lfsr_q       <= SEED_RESET;
      hit_cnt_q    <= '0;
      fault_cnt_q  <= '0;
      slot_valid_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_take) begin
        unique case (cfg_i.index)
          CFG_PAGE_SIZE: begin
            psize_cfg_q <= cfg_i.data[PSIZE_W-1:0];
          end
          CFG_VICTIM_SEED: begin
            lfsr_q <= (cfg_i.data[LFSR_W-1:0] == '0) ? SEED_RESET
                                                      : cfg_i.data[LFSR_W-1:0];
          end
          default: ;
        endcase
      end
      if (cmd_i.resolve) begin
        if (hit_any) begin
          hit_cnt_q <= hit_cnt_inc;
        end else begin
          fault_cnt_q          <= fault_cnt_inc;
          lfsr_q               <= lfsr_next;
          slot_valid_q[vrem_q] <= 1'b1;
        end
      end
      if (cmd_i.flush_emit) begin
        slot_valid_q[cmd_i.ptr] <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ps_q   <= ps_use;
      quo_q  <= word_index_i;
      rem_q  <= '0;
      vrem_q <= SLOT_W'(lfsr_next % LFSR_W'(SLOT_COUNT));
    end
    if (cmd_i.step) begin
      quo_q <= {quo_q[IDX_W-2:0], trial_ge};
      rem_q <= trial_ge ? trial_sub[OFF_W-1:0] : trial[OFF_W-1:0];
    end
    if (cmd_i.resolve && !hit_any) begin
      slot_page_q[vrem_q] <= quo_q;
    end

    if (cmd_i.resolve) begin
      out_q.hit             <= hit_any;
      out_q.slot            <= slot_field(hit_any ? hit_idx : vrem_q);
      out_q.offset          <= rem_q;
      out_q.page_number     <= quo_q;
      out_q.writeback_valid <= !hit_any && rd_valid;
      out_q.writeback_page  <= (!hit_any && rd_valid) ? rd_page : '0;
      out_q.hit_total       <= hit_any ? hit_cnt_inc : hit_cnt_q;
      out_q.fault_total     <= hit_any ? fault_cnt_q : fault_cnt_inc;
      out_q.last            <= 1'b1;
    end else if (cmd_i.flush_emit) begin
      out_q.hit             <= 1'b0;
      out_q.slot            <= slot_field(cmd_i.ptr);
      out_q.offset          <= '0;
      out_q.page_number     <= '0;
      out_q.writeback_valid <= 1'b1;
      out_q.writeback_page  <= rd_page;
      out_q.hit_total       <= hit_cnt_q;
      out_q.fault_total     <= fault_cnt_q;
      out_q.last            <= !above;
    end else if (cmd_i.flush_empty) begin
      out_q.hit             <= 1'b0;
      out_q.slot            <= '0;
      out_q.offset          <= '0;
      out_q.page_number     <= '0;
      out_q.writeback_valid <= 1'b0;
      out_q.writeback_page  <= '0;
      out_q.hit_total       <= hit_cnt_q;
      out_q.fault_total     <= fault_cnt_q;
      out_q.last            <= 1'b1;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.hit             = out_q.hit;
  assign out_o.slot            = out_q.slot;
  assign out_o.offset          = out_q.offset;
  assign out_o.page_number     = out_q.page_number;
  assign out_o.writeback_valid = out_q.writeback_valid;
  assign out_o.writeback_page  = out_q.writeback_page;
  assign out_o.hit_total       = out_q.hit_total;
  assign out_o.fault_total     = out_q.fault_total;
  assign out_o.last            = out_q.last;

endmodule

[rtl/paged_index_slot_cache_top.sv]
// channel  dir  beat
// in_i     in   kind, word_index
// out_o    out  hit, slot, offset, page_number, writeback_valid, writeback_page,
//               hit_total, fault_total, last
// cfg_i    in   index (0 page_size, 1 victim_seed), data
//
// an access passes the accept state, 32 steps of the serial divider
// (one quotient bit per step) and one lookup/replace state
// a flush emits one result per loaded slot, skipping empty ones (one empty result if none)
// rst_ni is asynchronous; slots, counters and config load their reset values at once
// a result waits in the output register; the next item is taken meanwhile,
// and lookup or flush results stall only while that register is still full
module paged_index_slot_cache_top
  import pisc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  pisc_in_if.sink    in_i,
  pisc_cfg_if.sink   cfg_i,
  pisc_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  pisc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pisc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_index_i (in_i.word_index),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_i        (cfg_i),
    .out_o        (out_o)
  );

endmodule
